FILE: sv/tce_pkg.sv
package tce_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths of the item channels.
  localparam int OP_W       = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int ATTR_W     = 2 * COLOR_W;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int COLUMN_W   = 7;
  localparam int ROW_W      = 5;

  // Tab stops fall on multiples of this step (a power of two).
  localparam int TAB_STEP = 4;

  // Control characters recognised by a put item.
  localparam logic [CHAR_W-1:0] CH_BELL = 8'd7;
  localparam logic [CHAR_W-1:0] CH_BS   = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 2'd0,
    OP_SET_POS = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic copy;
    logic fill;
    logic cap_cell;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic need_scroll;
    logic rd_last;
    logic wr_last;
    logic out_free;
  } status_t;

endpackage

FILE: sv/tce_req_if.sv
interface tce_req_if import tce_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  fg_color;
  logic [COLOR_W-1:0]  bg_color;
  logic [COLUMN_W-1:0] column;
  logic [ROW_W-1:0]    row;

  modport source (
    output valid, op, char_code, fg_color, bg_color, column, row,
    input  ready
  );

  modport sink (
    input  valid, op, char_code, fg_color, bg_color, column, row,
    output ready
  );

endinterface

FILE: sv/tce_rsp_if.sv
interface tce_rsp_if import tce_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [COLUMN_W-1:0] cursor_column;
  logic [ROW_W-1:0]    cursor_row;
  logic                scrolled;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attr;

  modport source (
    output valid, cursor_column, cursor_row, scrolled, cell_char, cell_attr,
    input  ready
  );

  modport sink (
    input  valid, cursor_column, cursor_row, scrolled, cell_char, cell_attr,
    output ready
  );

endinterface

FILE: sv/text_console_engine_core.sv
// Text console engine: a ROWS x COLUMNS screen of character and attribute
// cells with a cursor, driven by one item at a time on the req channel.
// An item is accepted when req.valid and req.ready are both high, and each
// item gives exactly one result item on the rsp channel (valid/ready).
// Operations: put character, set cursor position, clear screen, read cell.
// A put or set position passes through the execute and done states; a read
// cell also passes a cell capture state. A put that scrolls walks the screen
// store, copying and then zeroing the last row. A clear zeroes the store one
// cell a cycle. The screen store has a single write port. Items are taken one
// at a time: a new item is accepted only after the result of the previous one
// has been loaded into the output register.
// After reset the block zeroes the store and holds req.ready low meanwhile;
// the cursor starts at column 0, row 0.
// A result waits in the output register while rsp.ready is low; the next
// item may be accepted and worked on, and its result waits until the
// register is free.
module text_console_engine_core import tce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic       clk,
  input logic       rst,
  tce_req_if.sink   req,
  tce_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t status;
  logic    ready;

  assign req.ready = ready;

  // Sequencer.
  tce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Cursor, screen store and result register.
  tce_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .op        (req.op),
    .char_code (req.char_code),
    .fg_color  (req.fg_color),
    .bg_color  (req.bg_color),
    .column    (req.column),
    .row       (req.row),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // No item is taken while the store is being swept.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ready |-> !(cmd.fill || cmd.copy))
    else $error("item accepted during a store sweep");

  // A scrolled result leaves the cursor on the last row.
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.scrolled |-> rsp.cursor_row == ROW_W'(ROWS - 1))
    else $error("scrolled result not on the last row");

  // Only a read item returns cell contents, and a read never scrolls.
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.scrolled |-> rsp.cell_char == '0 && rsp.cell_attr == '0)
    else $error("scrolled result carries cell data");

  // A result is loaded only into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !rsp.valid || rsp.ready)
    else $error("result overwritten before it was taken");
`endif

endmodule

FILE: sv/tce_ram.sv
module tce_ram import tce_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tce_ctrl.sv
module tce_ctrl import tce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the screen store.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (status.wr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.op)
          OP_PUT:     state_next = status.need_scroll ? ST_COPY : ST_DONE;
          OP_CLEAR:   state_next = ST_FILL;
          OP_READ:    state_next = ST_READ;
          OP_SET_POS: state_next = ST_DONE;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_COPY: begin
        if (status.rd_last) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (status.wr_last) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_INIT: cmd.fill = 1'b1;
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_EXEC: cmd.exec     = 1'b1;
      ST_COPY: cmd.copy     = 1'b1;
      ST_FILL: cmd.fill     = 1'b1;
      ST_READ: cmd.cap_cell = 1'b1;
      ST_DONE: cmd.emit     = status.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule

FILE: sv/tce_dp.sv
module tce_dp import tce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [OP_W-1:0]     op,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [COLOR_W-1:0]  fg_color,
  input  logic [COLOR_W-1:0]  bg_color,
  input  logic [COLUMN_W-1:0] column,
  input  logic [ROW_W-1:0]    row,
  tce_rsp_if.source           rsp
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // Latched item.
  op_t               op_q;
  logic [CHAR_W-1:0] char_q;
  logic [ATTR_W-1:0] attr_q;
  logic [CW-1:0]     col_in_q;
  logic [RW-1:0]     row_in_q;

  // Cursor and sweep state.
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     wr_ptr;
  logic              copy_pend;
  logic              scroll_flag;
  logic [CHAR_W-1:0] cell_char_q;
  logic [ATTR_W-1:0] cell_attr_q;

  logic [CW-1:0]     col_clamp;
  logic [RW-1:0]     row_clamp;
  logic [CW:0]       col_sum;
  logic [CW-1:0]     nxt_col;
  logic [RW-1:0]     nxt_row;
  logic              advance;
  logic              put_write;
  logic              need_scroll;
  logic [CW-1:0]     sel_col;
  logic [RW-1:0]     sel_row;
  logic [AW-1:0]     cell_addr;
  logic              sweep_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Saturate the requested position to the screen.
  always_comb begin
    col_clamp = (int'(column) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(column);
    row_clamp = (int'(row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(row);
  end

  // Cursor movement for a put item, before any scroll.
  always_comb begin
    nxt_col   = cur_col;
    nxt_row   = cur_row;
    advance   = 1'b0;
    put_write = 1'b0;
    col_sum   = {1'b0, cur_col} + (CW + 1)'(1);
    case (char_q)
      CH_BELL: begin
      end
      CH_LF: begin
        nxt_col = '0;
        nxt_row = cur_row + RW'(1);
      end
      CH_TAB: begin
        col_sum = {1'b0, cur_col} + (CW + 1)'(TAB_STEP)
                  - (CW + 1)'(cur_col % TAB_STEP);
        advance = 1'b1;
      end
      CH_BS: begin
        if (cur_col != '0) begin
          nxt_col = cur_col - CW'(1);
        end
      end
      CH_CR: begin
        nxt_col = '0;
      end
      default: begin
        put_write = 1'b1;
        advance   = 1'b1;
      end
    endcase
    if (advance) begin
      if (col_sum >= (CW + 1)'(COLUMNS)) begin
        nxt_col = CW'(col_sum - (CW + 1)'(COLUMNS));
        nxt_row = cur_row + RW'(1);
      end else begin
        nxt_col = CW'(col_sum);
      end
    end
  end

  assign need_scroll = (nxt_row == RW'(ROWS));

  // Cell address: the requested cell for a read, otherwise the cursor.
  always_comb begin
    sel_col   = (op_q == OP_READ) ? col_in_q : cur_col;
    sel_row   = (op_q == OP_READ) ? row_in_q : cur_row;
    cell_addr = AW'(AW'(sel_row) * AW'(COLUMNS)) + AW'(sel_col);
  end

  // Store ports. During a scroll each write stores the cell read in the cycle
  // before; the fill phase first lands the last copied cell and then writes zeros.
  always_comb begin
    sweep_we  = cmd.fill || (cmd.copy && copy_pend);
    ram_we    = (cmd.exec && op_q == OP_PUT && put_write) || sweep_we;
    ram_waddr = cmd.exec ? cell_addr : wr_ptr;
    ram_wdata = cmd.exec ? {attr_q, char_q} : (copy_pend ? ram_rdata : '0);
    ram_re    = cmd.copy || (cmd.exec && op_q == OP_READ);
    ram_raddr = cmd.copy ? rd_ptr : cell_addr;
  end

  tce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Item latch and per-item flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q        <= op_t'(op);
      char_q      <= char_code;
      attr_q      <= {bg_color, fg_color};
      col_in_q    <= col_clamp;
      row_in_q    <= row_clamp;
      cell_char_q <= '0;
      cell_attr_q <= '0;
    end else if (cmd.cap_cell) begin
      cell_char_q <= ram_rdata[CHAR_W-1:0];
      cell_attr_q <= ram_rdata[CELL_W-1:CHAR_W];
    end
  end

  // Cursor update.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      scroll_flag <= 1'b0;
    end else if (cmd.load) begin
      scroll_flag <= 1'b0;
    end else if (cmd.exec) begin
      case (op_q)
        OP_PUT: begin
          cur_col     <= nxt_col;
          cur_row     <= need_scroll ? RW'(ROWS - 1) : nxt_row;
          scroll_flag <= need_scroll;
        end
        OP_SET_POS: begin
          cur_col <= col_in_q;
          cur_row <= row_in_q;
        end
        OP_CLEAR: begin
          cur_col <= '0;
          cur_row <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sweep pointers for clearing and scrolling.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      copy_pend <= 1'b0;
    end else begin
      copy_pend <= cmd.copy;
      if (cmd.load) begin
        wr_ptr <= '0;
        rd_ptr <= AW'(COLUMNS);
      end else begin
        if (sweep_we) begin
          wr_ptr <= wr_ptr + AW'(1);
        end
        if (cmd.copy) begin
          rd_ptr <= rd_ptr + AW'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.cursor_column <= COLUMN_W'(cur_col);
      rsp.cursor_row    <= ROW_W'(cur_row);
      rsp.scrolled      <= scroll_flag;
      rsp.cell_char     <= cell_char_q;
      rsp.cell_attr     <= cell_attr_q;
    end
  end

  // Status for the controller.
  always_comb begin
    status.op          = op_q;
    status.need_scroll = need_scroll;
    status.rd_last     = (rd_ptr == AW'(CELLS - 1));
    status.wr_last     = (wr_ptr == AW'(CELLS - 1));
    status.out_free    = !rsp.valid || rsp.ready;
  end

endmodule

FILE: bench/text_console_engine_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the console engine, keeps its own copy of the
// screen and cursor, and compares every result item with the prediction.
module text_console_engine_checker import tce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic clk,
  input  logic rst,
  tce_req_if   req,
  tce_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [COLUMN_W-1:0] cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic                scrolled;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
  } console_report_t;

  // Shadow copy of the screen store and the linear cursor.
  logic [CELL_W-1:0] shadow_screen [CELLS];
  int                shadow_cursor;

  // Reports expected from items already taken, oldest first.
  console_report_t   pending_reports [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Applies one item to the shadow state and returns the report it gives.
  function automatic console_report_t console_apply(
    op_t                 op,
    logic [CHAR_W-1:0]   ch,
    logic [COLOR_W-1:0]  fg,
    logic [COLOR_W-1:0]  bg,
    logic [COLUMN_W-1:0] col,
    logic [ROW_W-1:0]    row
  );
    console_report_t rep;
    int              col_sat;
    int              row_sat;
    int              cur_col;
    int              cur_row;
    int              next_pos;
    logic [CELL_W-1:0] cell_word;
    rep     = '0;
    col_sat = (int'(col) > COLUMNS - 1) ? COLUMNS - 1 : int'(col);
    row_sat = (int'(row) > ROWS - 1) ? ROWS - 1 : int'(row);
    cur_col = shadow_cursor % COLUMNS;
    cur_row = shadow_cursor / COLUMNS;
    case (op)
      OP_PUT: begin
        next_pos = shadow_cursor;
        case (ch)
          CH_BELL: ;
          CH_LF:   next_pos = (cur_row + 1) * COLUMNS;
          CH_TAB:  next_pos = shadow_cursor + TAB_STEP - (cur_col % TAB_STEP);
          CH_BS: begin
            if (cur_col != 0) next_pos = shadow_cursor - 1;
          end
          CH_CR:   next_pos = cur_row * COLUMNS;
          default: begin
            shadow_screen[shadow_cursor] = {bg, fg, ch};
            next_pos = shadow_cursor + 1;
          end
        endcase
        // Running off the last row moves every row up and blanks the bottom one.
        if (next_pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) shadow_screen[i] = shadow_screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_screen[i] = '0;
          rep.scrolled = 1'b1;
          next_pos = (ROWS - 1) * COLUMNS + next_pos % COLUMNS;
        end
        shadow_cursor = next_pos;
      end
      OP_SET_POS: shadow_cursor = row_sat * COLUMNS + col_sat;
      OP_CLEAR: begin
        foreach (shadow_screen[i]) shadow_screen[i] = '0;
        shadow_cursor = 0;
      end
      OP_READ: begin
        cell_word     = shadow_screen[row_sat * COLUMNS + col_sat];
        rep.cell_char = cell_word[CHAR_W-1:0];
        rep.cell_attr = cell_word[CELL_W-1:CHAR_W];
      end
      default: ;
    endcase
    rep.cursor_column = COLUMN_W'(shadow_cursor % COLUMNS);
    rep.cursor_row    = ROW_W'(shadow_cursor / COLUMNS);
    return rep;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before new items are taken in, so that a stray result
  // is never matched against the prediction of an item taken at the same edge.
  always @(posedge clk) begin
    console_report_t want;
    if (rst) begin
      foreach (shadow_screen[i]) shadow_screen[i] = '0;
      shadow_cursor = 0;
      pending_reports.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_reports.size() == 0) begin
          $error("Result item with no item pending: column %0d, row %0d",
                 rsp.cursor_column, rsp.cursor_row);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("cursor_column", want.cursor_column, rsp.cursor_column);
          compare_field("cursor_row", want.cursor_row, rsp.cursor_row);
          compare_field("scrolled", want.scrolled, rsp.scrolled);
          compare_field("cell_char", want.cell_char, rsp.cell_char);
          compare_field("cell_attr", want.cell_attr, rsp.cell_attr);
        end
      end
      if (req.valid && req.ready) begin
        pending_reports.push_back(console_apply(op_t'(req.op), req.char_code, req.fg_color,
                                                req.bg_color, req.column, req.row));
      end
    end
    outstanding = pending_reports.size();
  end

endmodule

FILE: bench/text_console_engine_core_tb.sv
`timescale 1ns / 1ps

module text_console_engine_core_tb;
  import tce_pkg::*;

  localparam int COLUMNS      = DEF_COLUMNS;
  localparam int ROWS         = DEF_ROWS;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS = 1075;
  localparam int MAX_WAIT     = 6;
  // Worst case: every item walks the whole store, plus both sides' longest waits.
  localparam int CYCLE_LIMIT  = (RANDOM_ITEMS + 40) * (CELLS + 4 * MAX_WAIT + 20) * 3
                                + 4 * CELLS;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  int   results_taken;

  tce_req_if req ();
  tce_rsp_if rsp ();

  text_console_engine_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  text_console_engine_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one item after a random gap and returns at the falling edge after
  // it has been taken. Valid stays high when the next gap is zero.
  task automatic send_item(
    op_t                 op,
    logic [CHAR_W-1:0]   ch,
    logic [COLOR_W-1:0]  fg,
    logic [COLOR_W-1:0]  bg,
    logic [COLUMN_W-1:0] col,
    logic [ROW_W-1:0]    row
  );
    int gap;
    gap = (((items_sent / 60) % 5) == 3) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.op        <= op;
    req.char_code <= ch;
    req.fg_color  <= fg;
    req.bg_color  <= bg;
    req.column    <= col;
    req.row       <= row;
    req.valid     <= 1'b1;
    do @(posedge clk); while (!req.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Builds one random item. Most are puts of text and control codes; cursor
  // moves favour the bottom rows so that the screen scrolls often.
  task automatic send_random_item();
    op_t                 op;
    logic [CHAR_W-1:0]   ch;
    logic [COLUMN_W-1:0] col;
    logic [ROW_W-1:0]    row;
    int                  pick;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    col  = COLUMN_W'($urandom_range(0, 127));
    row  = ROW_W'($urandom_range(0, 31));
    if (pick < 62) begin
      op = OP_PUT;
      case ($urandom_range(0, 9))
        0: ch = CH_LF;
        1: ch = CH_TAB;
        2: ch = CH_BS;
        3: ch = CH_CR;
        4: ch = CH_BELL;
        default: ;
      endcase
    end else if (pick < 74) begin
      op = OP_SET_POS;
      if ($urandom_range(0, 1) == 0) row = ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
      if ($urandom_range(0, 1) == 0) col = COLUMN_W'($urandom_range(COLUMNS - 6, COLUMNS - 1));
    end else if (pick < 99) begin
      op = OP_READ;
      if ($urandom_range(0, 3) != 0) begin
        row = ROW_W'($urandom_range(ROWS - 4, ROWS - 1));
        col = COLUMN_W'($urandom_range(0, COLUMNS - 1));
      end
    end else begin
      op = OP_CLEAR;
    end
    send_item(op, ch, COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)),
              col, row);
  endtask

  // Stimulus: reset, a directed walk through the control codes, wrapping and
  // saturation, then random items.
  initial begin
    rst           = 1'b1;
    items_sent    = 0;
    req.valid     = 1'b0;
    req.op        = OP_PUT;
    req.char_code = '0;
    req.fg_color  = '0;
    req.bg_color  = '0;
    req.column    = '0;
    req.row       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, 8'd65, 4'd15, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, 8'd0, 4'd0, 4'd15, 7'd0, 5'd0);
    send_item(OP_PUT, 8'd255, 4'd5, 4'd10, 7'd0, 5'd0);
    send_item(OP_PUT, CH_BELL, 4'd1, 4'd2, 7'd0, 5'd0);
    send_item(OP_PUT, CH_BS, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, CH_TAB, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, CH_TAB, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, CH_CR, 4'd0, 4'd0, 7'd0, 5'd0);
    // Backspace at the left margin leaves the cursor where it is.
    send_item(OP_PUT, CH_BS, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, CH_LF, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_READ, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0);
    // Positions beyond the screen saturate to the last column and row.
    send_item(OP_READ, 8'd0, 4'd0, 4'd0, 7'd127, 5'd31);
    send_item(OP_SET_POS, 8'd0, 4'd0, 4'd0, 7'd127, 5'd31);
    // A character in the bottom-right cell, a tab and a line feed on the
    // bottom row each scroll the screen.
    send_item(OP_PUT, 8'd122, 4'd3, 4'd12, 7'd0, 5'd0);
    send_item(OP_SET_POS, 8'd0, 4'd0, 4'd0, COLUMN_W'(COLUMNS - 2), ROW_W'(ROWS - 1));
    send_item(OP_PUT, CH_TAB, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_PUT, CH_LF, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_READ, 8'd0, 4'd0, 4'd0, COLUMN_W'(COLUMNS - 1), ROW_W'(ROWS - 4));
    send_item(OP_SET_POS, 8'd0, 4'd0, 4'd0, 7'd5, 5'd3);
    send_item(OP_PUT, 8'd126, 4'd10, 4'd5, 7'd0, 5'd0);
    send_item(OP_READ, 8'd0, 4'd0, 4'd0, 7'd5, 5'd3);
    send_item(OP_CLEAR, 8'd0, 4'd0, 4'd0, 7'd0, 5'd0);
    send_item(OP_READ, 8'd0, 4'd0, 4'd0, 7'd5, 5'd3);
    send_item(OP_SET_POS, 8'd0, 4'd0, 4'd0, 7'd85, 5'd21);

    repeat (RANDOM_ITEMS) send_random_item();
    req.valid <= 1'b0;

    // Drain: every result must come back before the verdict.
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, bursts with none, and two long hold-offs
  // that let the block fill up and stop taking items.
  initial begin
    int hold;
    results_taken = 0;
    rsp.ready     = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken == 150 || results_taken == 700) begin
        hold = 120;
      end else if (((results_taken / 45) % 5) == 1) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, MAX_WAIT);
      end
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      results_taken++;
      @(negedge clk);
    end
  end

  // Watchdog on the whole run.
  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("Run stopped by the cycle limit after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
